/* rtl/tber_pkg.sv */
// ----------------------------------------------------------------------------
// tber_pkg
// shared types and constants of the time-binned event recorder
// ----------------------------------------------------------------------------
package tber_pkg;

   // bin store geometry
   localparam int NUM_BINS    = 1024;
   localparam int COUNT_WIDTH = 8;
   localparam int BIN_AW      = $clog2(NUM_BINS);

   // configuration port
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_TICKS_PER_BIN = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BINS_IN_USE   = 1'b1;

   localparam logic [15:0] TICKS_PER_BIN_RESET = 16'd1000;
   localparam logic [10:0] BINS_IN_USE_RESET   = 11'd1024;

   // input item modes
   localparam logic [1:0] MODE_EVENT = 2'd0;
   localparam logic [1:0] MODE_TICK  = 2'd1;
   localparam logic [1:0] MODE_READ  = 2'd2;

   // operations handed from front to back
   localparam logic [1:0] OP_NONE = 2'd0;
   localparam logic [1:0] OP_INC  = 2'd1;
   localparam logic [1:0] OP_READ = 2'd2;

   typedef struct packed {
      logic [1:0] mode;
      logic [9:0] read_index;
   } req_type;

   typedef struct packed {
      logic [7:0]  read_count;
      logic [10:0] current_bin;
      logic [10:0] bins_recorded;
      logic [15:0] elapsed_ticks;
      logic        finished;
      logic        event_counted;
   } rsp_type;

   // one classified item on its way to the bin store
   typedef struct packed {
      logic [1:0]        op;
      logic [BIN_AW-1:0] addr;
      rsp_type           status;
   } cmd_type;

endpackage

/* rtl/tber_front.sv */
// ----------------------------------------------------------------------------
// tber_front
// accepts items, holds configuration and the bin/tick sequencer, queues
// classified commands for the bin store
// ----------------------------------------------------------------------------
module tber_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_push,
   output logic                               req_full,
   input  tber_pkg::req_type                  req_data,
   input  logic                               csr_we,
   input  logic [tber_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [tber_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic                               store_clearing,
   output logic                               cmd_valid,
   output tber_pkg::cmd_type                  cmd_data,
   input  logic                               cmd_pop
);
   import tber_pkg::*;

   logic [15:0] ticks_per_bin_ff, ticks_per_bin_in;
   logic [10:0] bins_in_use_ff, bins_in_use_in;
   logic [10:0] ptr_ff, ptr_in;
   logic [15:0] ticks_ff, ticks_in;
   logic        done_ff, done_in;

   cmd_type     queue_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  cnt_ff, cnt_in;

   logic        accept;
   logic [10:0] limit;
   logic [15:0] span;
   logic [16:0] tick_next;
   logic [10:0] ptr_step;
   logic        counted;
   cmd_type     cmd_new;

   assign req_full  = store_clearing || (cnt_ff == 2'd2);
   assign accept    = req_push && !req_full;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd_data  = queue_ff[rd_ptr_ff];

   // configuration
   always_comb begin
      ticks_per_bin_in = ticks_per_bin_ff;
      bins_in_use_in   = bins_in_use_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_TICKS_PER_BIN: ticks_per_bin_in = csr_wdata[15:0];
            CSR_BINS_IN_USE:   bins_in_use_in   = csr_wdata[10:0];
            default: ;
         endcase
      end
   end

   // effective bin limit and span
   always_comb begin
      if (bins_in_use_ff == 11'd0) begin
         limit = 11'd1;
      end else if (32'(bins_in_use_ff) > NUM_BINS) begin
         limit = 11'(NUM_BINS);
      end else begin
         limit = bins_in_use_ff;
      end
      span      = (ticks_per_bin_ff == 16'd0) ? 16'd1 : ticks_per_bin_ff;
      tick_next = {1'b0, ticks_ff} + 17'd1;
      ptr_step  = ptr_ff + 11'd1;
   end

   // sequencer and classification
   always_comb begin
      ptr_in   = ptr_ff;
      ticks_in = ticks_ff;
      done_in  = done_ff;
      counted  = 1'b0;
      cmd_new.op   = OP_NONE;
      cmd_new.addr = BIN_AW'(ptr_ff);
      case (req_data.mode)
         MODE_EVENT: begin
            if (!done_ff && (ptr_ff < limit)) begin
               counted    = 1'b1;
               cmd_new.op = OP_INC;
            end
         end
         MODE_TICK: begin
            if (!done_ff) begin
               if (tick_next >= {1'b0, span}) begin
                  ptr_in = ptr_step;
                  if (ptr_step < limit) begin
                     ticks_in = 16'd0;
                  end else begin
                     ticks_in = tick_next[15:0];
                     done_in  = 1'b1;
                  end
               end else begin
                  ticks_in = tick_next[15:0];
               end
            end
         end
         MODE_READ: begin
            cmd_new.addr = BIN_AW'(req_data.read_index);
            if (32'(req_data.read_index) < NUM_BINS) begin
               cmd_new.op = OP_READ;
            end
         end
         default: ;
      endcase
      cmd_new.status.read_count    = 8'd0;
      cmd_new.status.current_bin   = ptr_in;
      cmd_new.status.bins_recorded = done_in ? ptr_in : ptr_in + 11'd1;
      cmd_new.status.elapsed_ticks = ticks_in;
      cmd_new.status.finished      = done_in;
      cmd_new.status.event_counted = counted;
   end

   // command queue pointers
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (accept) begin
         wr_ptr_in = !wr_ptr_ff;
      end
      if (cmd_pop) begin
         rd_ptr_in = !rd_ptr_ff;
      end
      case ({accept, cmd_pop})
         2'b10:   cnt_in = cnt_ff + 2'd1;
         2'b01:   cnt_in = cnt_ff - 2'd1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_per_bin_ff <= TICKS_PER_BIN_RESET;
         bins_in_use_ff   <= BINS_IN_USE_RESET;
         ptr_ff           <= 11'd0;
         ticks_ff         <= 16'd0;
         done_ff          <= 1'b0;
         wr_ptr_ff        <= 1'b0;
         rd_ptr_ff        <= 1'b0;
         cnt_ff           <= 2'd0;
      end else begin
         ticks_per_bin_ff <= ticks_per_bin_in;
         bins_in_use_ff   <= bins_in_use_in;
         if (accept) begin
            ptr_ff   <= ptr_in;
            ticks_ff <= ticks_in;
            done_ff  <= done_in;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         queue_ff[wr_ptr_ff] <= cmd_new;
      end
   end

   a_no_accept_when_full: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd2) |-> !accept)
      else $error("command queue overrun");

   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> done_ff && $stable(ptr_ff))
      else $error("sequencer moved after finishing");

   a_queue_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3)
      else $error("command queue count out of range");

endmodule

/* rtl/tber_back.sv */
// ----------------------------------------------------------------------------
// tber_back
// bin store with clearing pass, read-modify-write of one bin, result queue
// ----------------------------------------------------------------------------
module tber_back (
   input  logic                 clock,
   input  logic                 reset,
   output logic                 store_clearing,
   input  logic                 cmd_valid,
   input  tber_pkg::cmd_type    cmd_data,
   output logic                 cmd_pop,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output tber_pkg::rsp_type    rsp_data
);
   import tber_pkg::*;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
   localparam logic [BIN_AW-1:0]      LAST_BIN  = BIN_AW'(NUM_BINS - 1);

   logic [COUNT_WIDTH-1:0] bins_mem [NUM_BINS];
   logic [COUNT_WIDTH-1:0] rd_data_ff;

   logic                   clear_ff, clear_in;
   logic [BIN_AW-1:0]      clr_addr_ff, clr_addr_in;
   logic                   busy_ff, busy_in;
   cmd_type                hold_ff;

   logic                   mem_we;
   logic [BIN_AW-1:0]      mem_wa;
   logic [COUNT_WIDTH-1:0] mem_wd;
   logic [COUNT_WIDTH-1:0] bumped;

   rsp_type                res_ff [2];
   logic                   res_wr_ff, res_wr_in;
   logic                   res_rd_ff, res_rd_in;
   logic [1:0]             res_cnt_ff, res_cnt_in;
   logic                   res_push;
   logic                   res_take;
   rsp_type                res_new;

   assign store_clearing = clear_ff;

   // one item in flight; launch only with room left in the result queue
   assign cmd_pop  = !clear_ff && !busy_ff && cmd_valid && (res_cnt_ff != 2'd2);
   assign res_push = busy_ff;
   assign res_take = rsp_pop && (res_cnt_ff != 2'd0);

   assign rsp_empty = (res_cnt_ff == 2'd0);
   assign rsp_data  = res_ff[res_rd_ff];

   assign bumped = (rd_data_ff == COUNT_MAX) ? rd_data_ff : rd_data_ff + 1'b1;

   always_comb begin
      res_new = hold_ff.status;
      if (hold_ff.op == OP_READ) begin
         res_new.read_count = 8'(rd_data_ff);
      end
   end

   always_comb begin
      mem_we = 1'b0;
      mem_wa = hold_ff.addr;
      mem_wd = bumped;
      if (clear_ff) begin
         mem_we = 1'b1;
         mem_wa = clr_addr_ff;
         mem_wd = '0;
      end else if (busy_ff && (hold_ff.op == OP_INC)) begin
         mem_we = 1'b1;
      end
   end

   always_comb begin
      clear_in    = clear_ff;
      clr_addr_in = clr_addr_ff;
      if (clear_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == LAST_BIN) begin
            clear_in = 1'b0;
         end
      end
      busy_in   = cmd_pop;
      res_wr_in = res_push ? !res_wr_ff : res_wr_ff;
      res_rd_in = res_take ? !res_rd_ff : res_rd_ff;
      case ({res_push, res_take})
         2'b10:   res_cnt_in = res_cnt_ff + 2'd1;
         2'b01:   res_cnt_in = res_cnt_ff - 2'd1;
         default: res_cnt_in = res_cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff    <= 1'b1;
         clr_addr_ff <= '0;
         busy_ff     <= 1'b0;
         res_wr_ff   <= 1'b0;
         res_rd_ff   <= 1'b0;
         res_cnt_ff  <= 2'd0;
      end else begin
         clear_ff    <= clear_in;
         clr_addr_ff <= clr_addr_in;
         busy_ff     <= busy_in;
         res_wr_ff   <= res_wr_in;
         res_rd_ff   <= res_rd_in;
         res_cnt_ff  <= res_cnt_in;
      end
   end

   // bin store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         bins_mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= bins_mem[cmd_data.addr];
   end

   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         hold_ff <= cmd_data;
      end
      if (res_push) begin
         res_ff[res_wr_ff] <= res_new;
      end
   end

   a_no_launch_while_clearing: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> !clear_ff)
      else $error("item launched during clearing pass");

   a_launch_then_result: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |=> busy_ff && !cmd_pop)
      else $error("read-modify-write sequencing broken");

   a_result_queue_bound: assert property (@(posedge clock) disable iff (reset)
      res_push |-> (res_cnt_ff != 2'd2) || res_take)
      else $error("result queue overrun");

endmodule

/* rtl/time_binned_event_recorder_top.sv */
// ----------------------------------------------------------------------------
// time_binned_event_recorder_top
// multichannel scaler: events counted into time bins measured out by ticks
// ----------------------------------------------------------------------------
// each transfer on the req side is an event, a tick or a read of one bin, and
// gives exactly one transfer on the rsp side carrying the bin count (reads
// only) and the recorder status after that item. after reset the bin store is
// swept to zero, one bin a cycle, and req_full stays high while the sweep runs;
// configuration writes are taken throughout. an item then passes the bin
// store as the read step and then the write-back step of its read-modify-write,
// and the next item starts only once the write-back is done. a result reaches
// the rsp side by way of the command queue, the bin store read register and
// the result queue. a two-entry command queue and a two-entry result queue
// let both sides stall on their own. write the configuration only while the
// block is idle
// ----------------------------------------------------------------------------
module time_binned_event_recorder_top (
   input  logic                               clock,
   input  logic                               reset,
   // input channel
   input  logic                               req_push,
   output logic                               req_full,
   input  tber_pkg::req_type                  req_data,
   // result channel
   output logic                               rsp_empty,
   input  logic                               rsp_pop,
   output tber_pkg::rsp_type                  rsp_data,
   // configuration writes
   input  logic                               csr_we,
   input  logic [tber_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [tber_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import tber_pkg::*;

   // front to back command handoff
   logic    cmd_valid;
   logic    cmd_pop;
   cmd_type cmd_data;
   // clearing pass in progress, holds off the input side
   logic    store_clearing;

   // front: configuration, bin/tick sequencer, classification
   tber_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_data       (req_data),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .store_clearing (store_clearing),
      .cmd_valid      (cmd_valid),
      .cmd_data       (cmd_data),
      .cmd_pop        (cmd_pop)
   );

   // back: bin store update and read-back, result queue
   tber_back u_back (
      .clock          (clock),
      .reset          (reset),
      .store_clearing (store_clearing),
      .cmd_valid      (cmd_valid),
      .cmd_data       (cmd_data),
      .cmd_pop        (cmd_pop),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_data       (rsp_data)
   );

endmodule
